>>> rtl/tsq_pkg.sv
package tsq_pkg;

  localparam int QUEUE_DEPTH  = 8;
  localparam int PAYLOAD_BITS = 32;

  localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W  = 64;
  localparam int AGE_W   = 32;
  localparam int LOST_W  = 32;
  localparam int FILL_W  = 4;
  localparam int PAY_W   = 32;

  localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(QUEUE_DEPTH - 1);
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);
  localparam logic [AGE_W-1:0]   AGE_RESET  = AGE_W'(100000);

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_DEC,
    S_FIN
  } state_t;

  // Outcome of the age check on one queue entry.
  typedef struct packed {
    logic newer;  // stamp lies after the horizon
    logic fresh;  // horizon - stamp within max_age
  } age_res_t;

  typedef struct packed {
    logic                    push_ok;
    logic                    found;
    logic [TIME_W-1:0]       out_time;
    logic [PAYLOAD_BITS-1:0] out_payload;
  } res_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

endpackage

>>> rtl/tsq_req_if.sv
interface tsq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [tsq_pkg::TIME_W-1:0] sample_time;
  logic [tsq_pkg::PAY_W-1:0]  sample_payload;
  logic [tsq_pkg::TIME_W-1:0] horizon_stamp;

  modport source (output valid, req_type, sample_time, sample_payload, horizon_stamp,
                  input ready);
  modport sink   (input valid, req_type, sample_time, sample_payload, horizon_stamp,
                  output ready);
endinterface

>>> rtl/tsq_rsp_if.sv
interface tsq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       push_ok;
  logic                       found;
  logic [tsq_pkg::TIME_W-1:0] out_time;
  logic [tsq_pkg::PAY_W-1:0]  out_payload;
  logic [tsq_pkg::FILL_W-1:0] fill_level;
  logic [tsq_pkg::LOST_W-1:0] overflow_total;

  modport source (output valid, push_ok, found, out_time, out_payload, fill_level,
                  overflow_total, input ready);
  modport sink   (input valid, push_ok, found, out_time, out_payload, fill_level,
                  overflow_total, output ready);
endinterface

>>> rtl/timestamped_queue_stale_drop_top.sv
// Push, or pop on an empty queue: the request goes to the finish state, which loads the
//   output register once that is free. Pop: each examined entry passes the read, compare
//   and decide states, then the finish state; each entry costs a memory read, a registered
//   64-bit subtract in the age unit and one decide step.
// One request is worked on at a time. Reset (rst, synchronous, active high) empties the
//   queue, clears the overflow count and loads max_age with 100000; memory is not cleared.
module timestamped_queue_stale_drop_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [tsq_pkg::AGE_W-1:0] cfg_wr_data,
  tsq_req_if.sink                   req,
  tsq_rsp_if.source                 rsp
);

  tsq_pkg::state_t   state, state_next;
  tsq_pkg::age_res_t age_res;
  tsq_pkg::res_t     res;

  logic [tsq_pkg::SLOT_W-1:0]       ws;     // next slot to write
  logic [tsq_pkg::SLOT_W-1:0]       head;   // oldest occupied slot
  logic [tsq_pkg::COUNT_W-1:0]      count;
  logic [tsq_pkg::LOST_W-1:0]       lost;
  logic [tsq_pkg::AGE_W-1:0]        max_age;
  logic [tsq_pkg::TIME_W-1:0]       horizon;

  logic [tsq_pkg::TIME_W-1:0]       rd_time;
  logic [tsq_pkg::PAYLOAD_BITS-1:0] rd_pay;

  logic out_valid;
  logic take;       // request handshake
  logic do_push;
  logic pop_start;
  logic remove;     // drop head entry in decide step (stale or released)
  logic release_hit;
  logic load_out;
  logic is_full;

  assign take      = req.valid && req.ready;
  assign do_push   = take && (req.req_type == tsq_pkg::REQ_PUSH);
  assign pop_start = take && (req.req_type == tsq_pkg::REQ_POP);
  assign is_full   = (count == tsq_pkg::FULL_COUNT);

  // Entry storage: written on push, read at the head slot every cycle.
  tsq_store u_store (
    .clk   (clk),
    .we    (do_push),
    .waddr (ws),
    .wtime (req.sample_time),
    .wpay  (req.sample_payload[tsq_pkg::PAYLOAD_BITS-1:0]),
    .raddr (head),
    .rtime (rd_time),
    .rpay  (rd_pay)
  );

  // Shared age unit: one entry per pass.
  tsq_age u_age (
    .clk     (clk),
    .stamp   (rd_time),
    .horizon (horizon),
    .max_age (max_age),
    .res     (age_res)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tsq_pkg::S_IDLE: begin
        if (pop_start && (count != '0)) state_next = tsq_pkg::S_RD;
        else if (take)                  state_next = tsq_pkg::S_FIN;
      end
      tsq_pkg::S_RD:  state_next = tsq_pkg::S_CMP;
      tsq_pkg::S_CMP: state_next = tsq_pkg::S_DEC;
      tsq_pkg::S_DEC: begin
        // Stop on a newer entry, a release, or the last stale entry.
        if (age_res.newer || age_res.fresh || (count == tsq_pkg::COUNT_W'(1)))
          state_next = tsq_pkg::S_FIN;
        else
          state_next = tsq_pkg::S_RD;
      end
      tsq_pkg::S_FIN: begin
        if (!out_valid || rsp.ready) state_next = tsq_pkg::S_IDLE;
      end
      default: state_next = tsq_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req.ready   = (state == tsq_pkg::S_IDLE);
    remove      = (state == tsq_pkg::S_DEC) && !age_res.newer;
    release_hit = remove && age_res.fresh;
    load_out    = (state == tsq_pkg::S_FIN) && (!out_valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tsq_pkg::S_IDLE;
      ws      <= '0;
      head    <= '0;
      count   <= '0;
      lost    <= '0;
      max_age <= tsq_pkg::AGE_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr_en) max_age <= cfg_wr_data;
      if (do_push) begin
        ws <= tsq_pkg::next_slot(ws);
        if (is_full) begin
          // Overwrite the oldest entry; saturate the loss count.
          head <= tsq_pkg::next_slot(head);
          if (lost != '1) lost <= lost + tsq_pkg::LOST_W'(1);
        end else begin
          count <= count + tsq_pkg::COUNT_W'(1);
        end
      end
      if (remove) begin
        head  <= tsq_pkg::next_slot(head);
        count <= count - tsq_pkg::COUNT_W'(1);
      end
    end
  end

  // Hold the horizon and build the result for the current request.
  always_ff @(posedge clk) begin
    if (take) begin
      horizon         <= req.horizon_stamp;
      res.push_ok     <= !(do_push && is_full);
      res.found       <= 1'b0;
      res.out_time    <= '0;
      res.out_payload <= '0;
    end else if (release_hit) begin
      res.found       <= 1'b1;
      res.out_time    <= rd_time;
      res.out_payload <= rd_pay;
    end
  end

  // Output register: lets the next request in while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.push_ok        <= res.push_ok;
      rsp.found          <= res.found;
      rsp.out_time       <= res.out_time;
      rsp.out_payload    <= tsq_pkg::PAY_W'(res.out_payload);
      rsp.fill_level     <= tsq_pkg::FILL_W'(count);
      rsp.overflow_total <= lost;
    end
  end

  assign rsp.valid = out_valid;

  // Occupancy never exceeds the ring depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= tsq_pkg::FULL_COUNT)
    else $error("entry count above queue depth");

  // An empty ring has its read and write slots together.
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (ws == head))
    else $error("empty queue with split pointers");

  // A stale entry is dropped; the walk goes on unless it was the last one.
  a_stale_drop: assert property (@(posedge clk) disable iff (rst)
    (state == tsq_pkg::S_DEC && !age_res.newer && !age_res.fresh)
    |=> (count == $past(count) - tsq_pkg::COUNT_W'(1)))
    else $error("stale entry not dropped");

  // A returned sample never comes with a loss report.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |-> rsp.push_ok)
    else $error("found result flags a loss");

endmodule

>>> rtl/tsq_store.sv
module tsq_store (
  input  logic                             clk,
  input  logic                             we,
  input  logic [tsq_pkg::SLOT_W-1:0]       waddr,
  input  logic [tsq_pkg::TIME_W-1:0]       wtime,
  input  logic [tsq_pkg::PAYLOAD_BITS-1:0] wpay,
  input  logic [tsq_pkg::SLOT_W-1:0]       raddr,
  output logic [tsq_pkg::TIME_W-1:0]       rtime,
  output logic [tsq_pkg::PAYLOAD_BITS-1:0] rpay
);

  logic [tsq_pkg::TIME_W-1:0]       time_mem [tsq_pkg::QUEUE_DEPTH];
  logic [tsq_pkg::PAYLOAD_BITS-1:0] pay_mem  [tsq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr] <= wtime;
      pay_mem[waddr]  <= wpay;
    end
  end

  always_ff @(posedge clk) begin
    rtime <= time_mem[raddr];
    rpay  <= pay_mem[raddr];
  end

endmodule

>>> rtl/tsq_age.sv
module tsq_age (
  input  logic                       clk,
  input  logic [tsq_pkg::TIME_W-1:0] stamp,
  input  logic [tsq_pkg::TIME_W-1:0] horizon,
  input  logic [tsq_pkg::AGE_W-1:0]  max_age,
  output tsq_pkg::age_res_t          res
);

  logic [tsq_pkg::TIME_W:0]   diff_full;
  logic                       borrow;
  logic [tsq_pkg::TIME_W-1:0] diff;

  assign diff_full = {1'b0, horizon} - {1'b0, stamp};

  // Register the wide subtract; compare against max_age afterwards.
  always_ff @(posedge clk) begin
    borrow <= diff_full[tsq_pkg::TIME_W];
    diff   <= diff_full[tsq_pkg::TIME_W-1:0];
  end

  always_comb begin
    res.newer = borrow;
    res.fresh = (diff[tsq_pkg::TIME_W-1:tsq_pkg::AGE_W] == '0)
                && (diff[tsq_pkg::AGE_W-1:0] <= max_age);
  end

endmodule
